>>> design/sts_pkg.sv
// sts_pkg: shared types, token and mode codes and character helpers for the scanner
// no dependencies
package sts_pkg;

  localparam int POSITION_BITS = 20;
  localparam int LINE_BITS = 16;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS = 2;

  localparam logic [POSITION_BITS-1:0] POS_TOP = {POSITION_BITS{1'b1}};
  localparam logic [LINE_BITS-1:0] LINE_TOP = {LINE_BITS{1'b1}};

  localparam logic [5:0] K_LPAREN = 6'd0;
  localparam logic [5:0] K_RPAREN = 6'd1;
  localparam logic [5:0] K_LBRACE = 6'd2;
  localparam logic [5:0] K_RBRACE = 6'd3;
  localparam logic [5:0] K_SEMI = 6'd4;
  localparam logic [5:0] K_COMMA = 6'd5;
  localparam logic [5:0] K_DOT = 6'd6;
  localparam logic [5:0] K_MINUS = 6'd7;
  localparam logic [5:0] K_PLUS = 6'd8;
  localparam logic [5:0] K_SLASH = 6'd9;
  localparam logic [5:0] K_STAR = 6'd10;
  localparam logic [5:0] K_BANG = 6'd11;
  localparam logic [5:0] K_EQUAL = 6'd13;
  localparam logic [5:0] K_GREATER = 6'd15;
  localparam logic [5:0] K_LESS = 6'd17;
  localparam logic [5:0] K_IDENT = 6'd19;
  localparam logic [5:0] K_STRING = 6'd20;
  localparam logic [5:0] K_NUMBER = 6'd21;
  localparam logic [5:0] K_KEYWORD0 = 6'd22;
  localparam logic [5:0] K_ERROR = 6'd38;
  localparam logic [5:0] K_EOF = 6'd39;

  localparam logic [1:0] E_NONE = 2'd0;
  localparam logic [1:0] E_UNTERM = 2'd1;
  localparam logic [1:0] E_UNEXP = 2'd2;

  typedef enum logic [3:0] {
    M_IDLE = 4'd0, M_SLASH = 4'd1, M_COMMENT = 4'd2, M_BANG = 4'd3,
    M_EQUAL = 4'd4, M_GREATER = 4'd5, M_LESS = 4'd6, M_IDENT = 4'd7,
    M_NUMBER = 4'd8, M_NUMDOT = 4'd9, M_FRACTION = 4'd10, M_STRING = 4'd11,
    M_ENDED = 4'd12
  } mode_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       end_of_input;
  } in_item_t;

  typedef struct packed {
    logic [5:0]  token_kind;
    logic [1:0]  error_kind;
    logic [19:0] start_offset;
    logic [19:0] lexeme_length;
    logic [15:0] line_number;
    logic        last_of_run;
  } out_item_t;

  // one raw token before offset and length saturation
  typedef struct packed {
    logic [5:0]               kind;
    logic [1:0]               err;
    logic [POSITION_BITS-1:0] start;
    logic [POSITION_BITS:0]   len;
    logic [LINE_BITS-1:0]     line;
  } tok_t;

  // a bundle of up to three tokens caused by one item
  typedef struct packed {
    logic [1:0] count;
    tok_t       t0;
    tok_t       t1;
    tok_t       t2;
  } bundle_t;

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic [19:0] sat20(input logic [POSITION_BITS:0] v);
    logic [32:0] w;
    w = 33'(v);
    return (w > 33'hFFFFF) ? 20'hFFFFF : w[19:0];
  endfunction

  function automatic logic [POSITION_BITS:0] span(input logic [POSITION_BITS-1:0] from,
                                                   input logic [POSITION_BITS-1:0] to);
    return (to > from) ? {1'b0, to - from} : '0;
  endfunction

endpackage

>>> design/script_token_scanner_core.sv
// script_token_scanner_core: streaming lexical scanner, one source byte per cycle
// a token's bundle is written into the bundle queue when the byte that ends it is taken
// one byte per cycle unless in_full; results drain one per out_pop, up to three per byte
// a four-entry bundle queue decouples the scanner from the result side
// reset: synchronous active-low rst_n clears mode, offsets, line count (to one) and queue
// depends on sts_pkg, sts_front, sts_back
module script_token_scanner_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  sts_pkg::in_item_t  in_item,
  output logic               out_empty,
  input  logic               out_pop,
  output sts_pkg::out_item_t out_item
);
  import sts_pkg::*;

  bundle_t bundle;
  logic take;

  assign take = in_push && !in_full;

  sts_front u_front (.clk(clk), .rst_n(rst_n), .take(take), .item(in_item), .bundle(bundle));
  sts_back u_back (.clk(clk), .rst_n(rst_n), .bwrite(take), .bundle(bundle), .bfull(in_full),
                   .out_empty(out_empty), .out_pop(out_pop), .out_item(out_item));
endmodule

>>> design/sts_front.sv
// sts_front: scanning state machine; classifies each byte and forms a token bundle
// depends on sts_pkg
module sts_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             take,
  input  sts_pkg::in_item_t item,
  output sts_pkg::bundle_t  bundle
);
  import sts_pkg::*;

  mode_t mode_r, mode_nxt;
  logic [POSITION_BITS-1:0] pos_r, pos_nxt, start_r, start_nxt;
  logic [LINE_BITS-1:0] line_r, line_nxt;
  logic [47:0] prefix_r, prefix_nxt;
  logic [2:0] wlen_r, wlen_nxt;

  logic [5:0] kw_kind;
  always_comb begin
    kw_kind = K_IDENT;
    case (wlen_r)
      3'd2: begin
        if (prefix_r[15:0] == 16'h6669) kw_kind = K_KEYWORD0 + 6'd6;
        if (prefix_r[15:0] == 16'h726f) kw_kind = K_KEYWORD0 + 6'd8;
      end
      3'd3: begin
        if (prefix_r[23:0] == 24'h646e61) kw_kind = K_KEYWORD0 + 6'd0;
        if (prefix_r[23:0] == 24'h726f66) kw_kind = K_KEYWORD0 + 6'd4;
        if (prefix_r[23:0] == 24'h6e7566) kw_kind = K_KEYWORD0 + 6'd5;
        if (prefix_r[23:0] == 24'h6c696e) kw_kind = K_KEYWORD0 + 6'd7;
        if (prefix_r[23:0] == 24'h726176) kw_kind = K_KEYWORD0 + 6'd14;
      end
      3'd4: begin
        if (prefix_r[31:0] == 32'h65736c65) kw_kind = K_KEYWORD0 + 6'd2;
        if (prefix_r[31:0] == 32'h73696874) kw_kind = K_KEYWORD0 + 6'd12;
        if (prefix_r[31:0] == 32'h65757274) kw_kind = K_KEYWORD0 + 6'd13;
      end
      3'd5: begin
        if (prefix_r[39:0] == 40'h7373616c63) kw_kind = K_KEYWORD0 + 6'd1;
        if (prefix_r[39:0] == 40'h65736c6166) kw_kind = K_KEYWORD0 + 6'd3;
        if (prefix_r[39:0] == 40'h746e697270) kw_kind = K_KEYWORD0 + 6'd9;
        if (prefix_r[39:0] == 40'h7265707573) kw_kind = K_KEYWORD0 + 6'd11;
        if (prefix_r[39:0] == 40'h656c696877) kw_kind = K_KEYWORD0 + 6'd15;
      end
      3'd6: begin
        if (prefix_r == 48'h6e7275746572) kw_kind = K_KEYWORD0 + 6'd10;
      end
      default: kw_kind = K_IDENT;
    endcase
  end

  always_comb begin
    tok_t t [3];
    logic [1:0] n;
    logic [7:0] c;
    logic [POSITION_BITS-1:0] p, dot;
    logic [LINE_BITS-1:0] ln;
    logic do_flush, do_fresh;
    logic [5:0] fk;
    logic femit;
    mode_t fmode;
    c = item.ch;
    p = pos_r;
    ln = line_r;
    n = 2'd0;
    for (int i = 0; i < 3; i++) t[i] = '0;
    mode_nxt = mode_r;
    pos_nxt = pos_r;
    start_nxt = start_r;
    line_nxt = line_r;
    prefix_nxt = prefix_r;
    wlen_nxt = wlen_r;
    do_flush = 1'b0;
    do_fresh = 1'b0;
    dot = (p > start_r) ? p - 1'b1 : p;
    fk = '0;
    femit = 1'b0;
    fmode = M_IDLE;

    if (mode_r == M_ENDED) begin
      t[0] = '{K_EOF, E_NONE, p, '0, ln};
      n = 2'd1;
    end else begin
      if (item.end_of_input || c == 8'd0) do_flush = 1'b1;
      else begin
        case (mode_r)
          M_IDENT: begin
            if (is_letter(c) || is_digit(c)) begin
              case (wlen_r)
                3'd0: prefix_nxt[7:0] = prefix_r[7:0] | c;
                3'd1: prefix_nxt[15:8] = prefix_r[15:8] | c;
                3'd2: prefix_nxt[23:16] = prefix_r[23:16] | c;
                3'd3: prefix_nxt[31:24] = prefix_r[31:24] | c;
                3'd4: prefix_nxt[39:32] = prefix_r[39:32] | c;
                3'd5: prefix_nxt[47:40] = prefix_r[47:40] | c;
                default: prefix_nxt = prefix_r;
              endcase
              if (wlen_r != 3'd7) wlen_nxt = wlen_r + 3'd1;
            end else begin
              do_flush = 1'b1; do_fresh = 1'b1;
            end
          end
          M_NUMBER: begin
            if (c == 8'h2e) mode_nxt = M_NUMDOT;
            else if (!is_digit(c)) begin do_flush = 1'b1; do_fresh = 1'b1; end
          end
          M_NUMDOT: begin
            if (is_digit(c)) mode_nxt = M_FRACTION;
            else begin do_flush = 1'b1; do_fresh = 1'b1; end
          end
          M_FRACTION: begin
            if (!is_digit(c)) begin do_flush = 1'b1; do_fresh = 1'b1; end
          end
          M_SLASH: begin
            if (c == 8'h2f) mode_nxt = M_COMMENT;
            else begin do_flush = 1'b1; do_fresh = 1'b1; end
          end
          M_COMMENT: begin
            if (c == 8'h0a) begin
              if (line_r != LINE_TOP) line_nxt = line_r + 1'b1;
              mode_nxt = M_IDLE;
            end
          end
          M_BANG, M_EQUAL, M_GREATER, M_LESS: begin
            if (c == 8'h3d) begin
              case (mode_r)
                M_BANG: fk = K_BANG + 6'd1;
                M_EQUAL: fk = K_EQUAL + 6'd1;
                M_GREATER: fk = K_GREATER + 6'd1;
                default: fk = K_LESS + 6'd1;
              endcase
              t[0] = '{fk, E_NONE, start_r, span(start_r, p) + 1'b1, ln};
              n = 2'd1;
              mode_nxt = M_IDLE;
            end else begin
              do_flush = 1'b1; do_fresh = 1'b1;
            end
          end
          M_STRING: begin
            if (c == 8'h0a) begin
              if (line_r != LINE_TOP) line_nxt = line_r + 1'b1;
            end else if (c == 8'h22) begin
              t[0] = '{K_STRING, E_NONE, start_r, span(start_r, p) + 1'b1, ln};
              n = 2'd1;
              mode_nxt = M_IDLE;
            end
          end
          default: do_fresh = 1'b1;
        endcase
        pos_nxt = (p != POS_TOP) ? p + 1'b1 : POS_TOP;
      end

      if (do_flush) begin
        mode_nxt = M_IDLE;
        case (mode_r)
          M_SLASH: begin t[n] = '{K_SLASH, E_NONE, start_r, 21'd1, ln}; n = n + 2'd1; end
          M_BANG: begin t[n] = '{K_BANG, E_NONE, start_r, 21'd1, ln}; n = n + 2'd1; end
          M_EQUAL: begin t[n] = '{K_EQUAL, E_NONE, start_r, 21'd1, ln}; n = n + 2'd1; end
          M_GREATER: begin
            t[n] = '{K_GREATER, E_NONE, start_r, 21'd1, ln}; n = n + 2'd1;
          end
          M_LESS: begin t[n] = '{K_LESS, E_NONE, start_r, 21'd1, ln}; n = n + 2'd1; end
          M_IDENT: begin
            t[n] = '{kw_kind, E_NONE, start_r, span(start_r, p), ln}; n = n + 2'd1;
          end
          M_NUMBER, M_FRACTION: begin
            t[n] = '{K_NUMBER, E_NONE, start_r, span(start_r, p), ln}; n = n + 2'd1;
          end
          M_NUMDOT: begin
            t[n] = '{K_NUMBER, E_NONE, start_r, span(start_r, dot), ln}; n = n + 2'd1;
            t[n] = '{K_DOT, E_NONE, dot, 21'd1, ln}; n = n + 2'd1;
          end
          M_STRING: begin
            t[n] = '{K_ERROR, E_UNTERM, start_r, span(start_r, p), ln}; n = n + 2'd1;
          end
          default: n = n;
        endcase
      end

      if (do_fresh) begin
        mode_nxt = M_IDLE;
        if (is_letter(c)) begin
          mode_nxt = M_IDENT; start_nxt = p; prefix_nxt = {40'd0, c}; wlen_nxt = 3'd1;
        end else if (is_digit(c)) begin
          mode_nxt = M_NUMBER; start_nxt = p;
        end else begin
          case (c)
            8'h28: begin femit = 1'b1; fk = K_LPAREN; end
            8'h29: begin femit = 1'b1; fk = K_RPAREN; end
            8'h7b: begin femit = 1'b1; fk = K_LBRACE; end
            8'h7d: begin femit = 1'b1; fk = K_RBRACE; end
            8'h3b: begin femit = 1'b1; fk = K_SEMI; end
            8'h2c: begin femit = 1'b1; fk = K_COMMA; end
            8'h2e: begin femit = 1'b1; fk = K_DOT; end
            8'h2d: begin femit = 1'b1; fk = K_MINUS; end
            8'h2b: begin femit = 1'b1; fk = K_PLUS; end
            8'h2a: begin femit = 1'b1; fk = K_STAR; end
            8'h2f: fmode = M_SLASH;
            8'h21: fmode = M_BANG;
            8'h3d: fmode = M_EQUAL;
            8'h3e: fmode = M_GREATER;
            8'h3c: fmode = M_LESS;
            8'h22: fmode = M_STRING;
            8'h20, 8'h0d, 8'h09: fmode = M_IDLE;
            8'h0a: begin
              if (line_r != LINE_TOP) line_nxt = line_r + 1'b1;
            end
            default: begin femit = 1'b1; fk = K_ERROR; end
          endcase
          if (fmode != M_IDLE) begin mode_nxt = fmode; start_nxt = p; end
          if (femit) begin
            t[n] = '{fk, (fk == K_ERROR) ? E_UNEXP : E_NONE, p, 21'd1, ln};
            n = n + 2'd1;
          end
        end
      end

      if (item.end_of_input || c == 8'd0) begin
        t[n] = '{K_EOF, E_NONE, p, '0, ln};
        n = n + 2'd1;
        mode_nxt = M_ENDED;
      end
    end
    bundle = '{n, t[0], t[1], t[2]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_IDLE;
      pos_r <= '0;
      start_r <= '0;
      line_r <= LINE_BITS'(1);
      prefix_r <= '0;
      wlen_r <= '0;
    end else if (take) begin
      mode_r <= mode_nxt;
      pos_r <= pos_nxt;
      start_r <= start_nxt;
      line_r <= line_nxt;
      prefix_r <= prefix_nxt;
      wlen_r <= wlen_nxt;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    take && mode_r == M_ENDED |=> mode_r == M_ENDED) else $error("left ended mode");
  assert property (@(posedge clk) disable iff (!rst_n)
    line_r != '0) else $error("line count zero");
  assert property (@(posedge clk) disable iff (!rst_n)
    take |-> bundle.count != 2'd0 || mode_nxt != M_ENDED) else $error("eof not emitted");
endmodule

>>> design/sts_back.sv
// sts_back: token bundle queue and serializer to the result queue interface
// depends on sts_pkg
module sts_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              bwrite,
  input  sts_pkg::bundle_t  bundle,
  output logic              bfull,
  output logic              out_empty,
  input  logic              out_pop,
  output sts_pkg::out_item_t out_item
);
  import sts_pkg::*;

  bundle_t q_r [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wp_r, rp_r;
  logic [QPTR_BITS:0] cnt_r;
  logic [1:0] sub_r;
  bundle_t head;
  tok_t cur;
  logic done, rd, wr;

  assign head = q_r[rp_r];
  assign out_empty = (cnt_r == '0);
  assign bfull = (cnt_r == (QPTR_BITS+1)'(QUEUE_DEPTH));
  always_comb begin
    case (sub_r)
      2'd0: cur = head.t0;
      2'd1: cur = head.t1;
      default: cur = head.t2;
    endcase
  end
  assign done = (sub_r + 2'd1 == head.count);
  assign rd = out_pop && !out_empty;
  assign wr = bwrite && bundle.count != 2'd0;
  assign out_item = '{cur.kind, cur.err, sat20({1'b0, cur.start}), sat20(cur.len),
                      cur.line[15:0], done};

  always_ff @(posedge clk) begin
    if (wr) q_r[wp_r] <= bundle;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0; sub_r <= '0;
    end else begin
      if (wr) wp_r <= wp_r + 1'b1;
      if (rd) begin
        if (done) begin
          rp_r <= rp_r + 1'b1; sub_r <= '0;
        end else sub_r <= sub_r + 2'd1;
      end
      cnt_r <= cnt_r + (QPTR_BITS+1)'(wr) - (QPTR_BITS+1)'(rd && done);
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    !(wr && bfull)) else $error("queue overflow");
  assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> head.count != 2'd0) else $error("empty bundle queued");
  assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (QPTR_BITS+1)'(QUEUE_DEPTH)) else $error("count out of range");
endmodule
